// ===== rtl/gsvp_pkg.sv =====
// Package with shared constants and types of the vertex partitioner.
package gsvp_pkg;

  localparam int unsigned MaxPartsDefault = 16;
  localparam int unsigned VertexBitsDefault = 16;
  localparam int unsigned PartWidth = 5;
  localparam int unsigned TotalWidth = 17;
  localparam int unsigned ModeWidth = 2;
  localparam int unsigned LinkWidth = 16;
  localparam int unsigned SizeWidth = 17;
  localparam int unsigned ChosenWidth = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned ScoreWidth = 40;

  localparam logic [CfgIdxWidth-1:0] CfgNumParts = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTotalVertices = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgScoreMode = 2'd2;

  localparam logic [ModeWidth-1:0] ModeGreedy = 2'd0;
  localparam logic [ModeWidth-1:0] ModeLinear = 2'd1;
  localparam logic [ModeWidth-1:0] ModeNonNeighbor = 2'd2;
  localparam logic [ModeWidth-1:0] ModeReserved = 2'd3;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StLookup,
    StCount,
    StMul,
    StProd,
    StScan,
    StFallback,
    StCommit,
    StClear,
    StOut
  } state_e;

  typedef struct packed {
    logic capture;
    logic count;
    logic scan_start;
    logic scan_step;
    logic mul;
    logic prod;
    logic fb_start;
    logic fb_step;
    logic commit;
    logic clear_step;
    logic init_step;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic seeding;
    logic scan_done;
    logic found;
    logic init_done;
  } status_t;

endpackage

// ===== rtl/gsvp_datapath.sv =====
// Datapath of the partitioner: vertex map, partition sizes, link counts and scoring.
module gsvp_datapath #(
  parameter int unsigned MaxParts = gsvp_pkg::MaxPartsDefault,
  parameter int unsigned VertexBits = gsvp_pkg::VertexBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsvp_pkg::cmd_t                      cmd_i,
  output gsvp_pkg::status_t                   status_o,
  input  logic [VertexBits-1:0]               vertex_id_i,
  input  logic [VertexBits-1:0]               neighbor_id_i,
  input  logic                                has_neighbor_i,
  input  logic                                last_neighbor_i,
  input  logic [gsvp_pkg::PartWidth-1:0]      num_parts_i,
  input  logic [gsvp_pkg::TotalWidth-1:0]     total_vertices_i,
  input  logic [gsvp_pkg::ModeWidth-1:0]      score_mode_i,
  output logic [VertexBits-1:0]               placed_vertex_o,
  output logic [gsvp_pkg::ChosenWidth-1:0]    chosen_part_o,
  output logic [gsvp_pkg::LinkWidth-1:0]      links_in_part_o,
  output logic                                fell_back_o
);

  localparam int unsigned PIdx = $clog2(MaxParts);
  localparam int unsigned KW = $clog2(MaxParts + 1);
  localparam int unsigned EntW = PIdx + 1;
  localparam int unsigned MapDepth = 1 << VertexBits;
  localparam int unsigned SW = gsvp_pkg::SizeWidth;
  localparam int unsigned LW = gsvp_pkg::LinkWidth;
  localparam int unsigned TW = gsvp_pkg::TotalWidth;
  localparam int unsigned ScW = gsvp_pkg::ScoreWidth;
  localparam int unsigned FacW = SW + KW + 1;

  logic [EntW-1:0] map_mem [MapDepth];
  logic [EntW-1:0] rd_q;
  logic [VertexBits-1:0] clr_q;

  logic [SW-1:0] size_q [MaxParts];
  logic [LW-1:0] link_q [MaxParts];
  logic [KW-1:0] seeded_q;

  logic [VertexBits-1:0] vid_q;
  logic has_q, last_q;

  logic [KW-1:0] k;
  logic [PIdx-1:0] idx_q, best_q;
  logic signed [ScW-1:0] best_w_q, w_q;
  logic signed [FacW-1:0] fac_q;
  logic found_q, fb_q;
  logic [SW-1:0] best_sz_q;

  always_comb begin
    if (num_parts_i == '0) begin
      k = KW'(1);
    end else if (32'(num_parts_i) > MaxParts) begin
      k = KW'(MaxParts);
    end else begin
      k = KW'(num_parts_i);
    end
  end

  logic [TW-1:0] n_eff;
  assign n_eff = (total_vertices_i == '0) ? TW'(1) : total_vertices_i;

  // Map memory: cleared entry by entry after reset, read for neighbor lookup, written at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= map_mem[neighbor_id_i];
    end
    if (cmd_i.init_step) begin
      map_mem[clr_q] <= '0;
    end else if (cmd_i.commit) begin
      map_mem[vid_q] <= {1'b1, best_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.init_step) begin
      clr_q <= clr_q + VertexBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vid_q <= vertex_id_i;
      has_q <= has_neighbor_i;
      last_q <= last_neighbor_i;
    end
  end

  logic [PIdx-1:0] np;
  assign np = rd_q[PIdx-1:0];

  // Score of partition idx_q, selected per mode.
  logic [LW-1:0] lc;
  logic [SW-1:0] sz;
  logic signed [LW:0] lc_ext;
  logic signed [FacW-1:0] fac;
  logic signed [ScW-1:0] prod;
  assign lc = link_q[idx_q];
  assign sz = size_q[idx_q];
  assign lc_ext = $signed({1'b0, lc});
  assign fac = $signed(FacW'(n_eff)) - $signed(FacW'(sz)) * $signed(FacW'(k));
  assign prod = ScW'(lc_ext) * ScW'(fac_q);

  logic signed [ScW-1:0] w_d;
  always_comb begin
    unique case (score_mode_i)
      gsvp_pkg::ModeLinear: w_d = prod;
      gsvp_pkg::ModeNonNeighbor: w_d = $signed(ScW'(sz)) - $signed(ScW'(lc));
      default: w_d = $signed(ScW'(lc));
    endcase
  end

  logic is_last_idx;
  assign is_last_idx = (KW'(idx_q) == k - KW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxParts; i++) begin
        size_q[i] <= '0;
        link_q[i] <= '0;
      end
      seeded_q <= '0;
      idx_q <= '0;
      best_q <= '0;
      best_w_q <= '0;
      w_q <= '0;
      fac_q <= '0;
      found_q <= 1'b0;
      fb_q <= 1'b0;
      best_sz_q <= '0;
      placed_vertex_o <= '0;
      chosen_part_o <= '0;
      links_in_part_o <= '0;
      fell_back_o <= 1'b0;
    end else begin
      if (cmd_i.count && has_q && rd_q[EntW-1] && (KW'(np) < k) &&
          (link_q[np] != '1)) begin
        link_q[np] <= link_q[np] + LW'(1);
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
        best_w_q <= '0;
        found_q <= 1'b0;
        if (status_o.seeding) begin
          best_q <= PIdx'(seeded_q);
          seeded_q <= seeded_q + KW'(1);
          fb_q <= 1'b1;
        end else begin
          best_q <= '0;
          fb_q <= 1'b0;
        end
      end
      if (cmd_i.mul) begin
        fac_q <= fac;
      end
      if (cmd_i.prod) begin
        w_q <= w_d;
      end
      if (cmd_i.scan_step) begin
        if (score_mode_i == gsvp_pkg::ModeNonNeighbor) begin
          if (idx_q == '0 || w_q < best_w_q) begin
            best_w_q <= w_q;
            best_q <= idx_q;
          end
          found_q <= 1'b1;
        end else if (w_q > best_w_q) begin
          best_w_q <= w_q;
          best_q <= idx_q;
          found_q <= 1'b1;
        end
        if (!is_last_idx) begin
          idx_q <= idx_q + PIdx'(1);
        end
      end
      if (cmd_i.fb_start) begin
        idx_q <= PIdx'(1);
        best_q <= '0;
        best_sz_q <= size_q[0];
        fb_q <= 1'b1;
      end
      if (cmd_i.fb_step) begin
        if (KW'(idx_q) < k && sz < best_sz_q) begin
          best_q <= idx_q;
          best_sz_q <= sz;
        end
        idx_q <= idx_q + PIdx'(1);
      end
      if (cmd_i.commit) begin
        if (size_q[best_q] != '1) begin
          size_q[best_q] <= size_q[best_q] + SW'(1);
        end
        placed_vertex_o <= vid_q;
        chosen_part_o <= gsvp_pkg::ChosenWidth'(32'(best_q));
        links_in_part_o <= link_q[best_q];
        fell_back_o <= fb_q;
        idx_q <= '0;
      end
      if (cmd_i.clear_step) begin
        for (int i = 0; i < MaxParts; i++) begin
          link_q[i] <= '0;
        end
      end
    end
  end

  assign status_o.last = last_q;
  assign status_o.seeding = (seeded_q < k);
  assign status_o.scan_done = is_last_idx;
  assign status_o.found = found_q;
  assign status_o.init_done = (clr_q == '1);

endmodule

// ===== rtl/gsvp_ctrl.sv =====
// Controller state machine of the partitioner.
module gsvp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsvp_pkg::cmd_t    cmd_o,
  input  gsvp_pkg::status_t status_i,
  input  logic              fb_done_i
);

  gsvp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsvp_pkg::StInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      gsvp_pkg::StInit: begin
        cmd_o.init_step = 1'b1;
        if (status_i.init_done) begin
          state_d = gsvp_pkg::StIdle;
        end
      end
      gsvp_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = gsvp_pkg::StCount;
        end
      end
      gsvp_pkg::StCount: begin
        cmd_o.count = 1'b1;
        state_d = status_i.last ? gsvp_pkg::StLookup : gsvp_pkg::StIdle;
      end
      gsvp_pkg::StLookup: begin
        cmd_o.scan_start = 1'b1;
        state_d = status_i.seeding ? gsvp_pkg::StCommit : gsvp_pkg::StMul;
      end
      gsvp_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d = gsvp_pkg::StProd;
      end
      gsvp_pkg::StProd: begin
        cmd_o.prod = 1'b1;
        state_d = gsvp_pkg::StScan;
      end
      gsvp_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        state_d = status_i.scan_done ? gsvp_pkg::StClear : gsvp_pkg::StMul;
      end
      gsvp_pkg::StClear: begin
        if (status_i.found) begin
          state_d = gsvp_pkg::StCommit;
        end else begin
          cmd_o.fb_start = 1'b1;
          state_d = gsvp_pkg::StFallback;
        end
      end
      gsvp_pkg::StFallback: begin
        cmd_o.fb_step = 1'b1;
        if (fb_done_i) begin
          state_d = gsvp_pkg::StCommit;
        end
      end
      gsvp_pkg::StCommit: begin
        cmd_o.commit = 1'b1;
        cmd_o.clear_step = 1'b1;
        state_d = gsvp_pkg::StOut;
      end
      gsvp_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = gsvp_pkg::StIdle;
        end
      end
      default: state_d = gsvp_pkg::StIdle;
    endcase
  end

endmodule

// ===== rtl/greedy_stream_vertex_partitioner_top.sv =====
// Top level of the streaming greedy vertex partitioner.
// After reset the vertex map is cleared one entry per cycle, and no word is taken until
// that pass ends. A neighbor word that is not last goes through a map read and then a
// link-count update. A last word then also starts the choice; while partitions are still
// being seeded it goes straight to the commit. Otherwise the scan steps through factor,
// product and compare for each active partition and then a decision step, then a
// least-loaded pass when no score is positive (never in the non-neighbor mode), and the
// commit. The result is then held until taken, and the next word is accepted in the cycle
// after that. Configuration should only be written while no vertex is in flight.
module greedy_stream_vertex_partitioner_top #(
  parameter int unsigned MaxParts = gsvp_pkg::MaxPartsDefault,
  parameter int unsigned VertexBits = gsvp_pkg::VertexBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [VertexBits-1:0]            vertex_id_i,
  input  logic [VertexBits-1:0]            neighbor_id_i,
  input  logic                             has_neighbor_i,
  input  logic                             last_neighbor_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [VertexBits-1:0]            placed_vertex_o,
  output logic [gsvp_pkg::ChosenWidth-1:0] chosen_part_o,
  output logic [gsvp_pkg::LinkWidth-1:0]   links_in_part_o,
  output logic                             fell_back_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gsvp_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int unsigned FbW = $clog2(MaxParts + 1);

  logic [gsvp_pkg::PartWidth-1:0]  num_parts_q;
  logic [gsvp_pkg::TotalWidth-1:0] total_q;
  logic [gsvp_pkg::ModeWidth-1:0]  mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_parts_q <= gsvp_pkg::PartWidth'(4);
      total_q <= gsvp_pkg::TotalWidth'(65536);
      mode_q <= gsvp_pkg::ModeLinear;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsvp_pkg::CfgNumParts: num_parts_q <= cfg_data_i[gsvp_pkg::PartWidth-1:0];
        gsvp_pkg::CfgTotalVertices: total_q <= cfg_data_i[gsvp_pkg::TotalWidth-1:0];
        gsvp_pkg::CfgScoreMode: mode_q <= cfg_data_i[gsvp_pkg::ModeWidth-1:0];
        default: ;
      endcase
    end
  end

  gsvp_pkg::cmd_t cmd;
  gsvp_pkg::status_t status;
  logic [FbW-1:0] fb_cnt_q;
  logic fb_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_cnt_q <= '0;
    end else if (cmd.fb_start) begin
      fb_cnt_q <= '0;
    end else if (cmd.fb_step) begin
      fb_cnt_q <= fb_cnt_q + FbW'(1);
    end
  end
  assign fb_done = (32'(fb_cnt_q) >= MaxParts - 2);

  gsvp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .fb_done_i   (fb_done)
  );

  gsvp_datapath #(
    .MaxParts   (MaxParts),
    .VertexBits (VertexBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .vertex_id_i      (vertex_id_i),
    .neighbor_id_i    (neighbor_id_i),
    .has_neighbor_i   (has_neighbor_i),
    .last_neighbor_i  (last_neighbor_i),
    .num_parts_i      (num_parts_q),
    .total_vertices_i (total_q),
    .score_mode_i     (mode_q),
    .placed_vertex_o  (placed_vertex_o),
    .chosen_part_o    (chosen_part_o),
    .links_in_part_o  (links_in_part_o),
    .fell_back_o      (fell_back_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o) else $error("commit without result");

endmodule
